// ===== sv/decimal_scientific_string_scanner_macros.svh =====
`ifndef DECIMAL_SCIENTIFIC_STRING_SCANNER_MACROS_SVH
`define DECIMAL_SCIENTIFIC_STRING_SCANNER_MACROS_SVH

// same-cycle implication, held off while reset is low
`define DSSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is low
`define DSSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dsss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dsss_pkg;

	localparam int MAX_DIGITS = 19;
	localparam int EXP_LIMIT  = 16383;
	localparam int CNT_W      = 5;
	localparam int EACC_W     = 14;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_PLUS,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_POINT,
		CLS_EXP,
		CLS_NUL,
		CLS_OTHER
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		logic        last;
	} token_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_INT,
		PH_FRAC,
		PH_SKIP,
		PH_EXP_START,
		PH_EXP_DIGITS,
		PH_DONE
	} phase_t;

	function automatic logic [63:0] pow10(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	localparam logic [63:0] MANT_MAX      = pow10(MAX_DIGITS) - 64'd1;
	localparam logic [63:0] MANT_FULL_MIN = pow10(MAX_DIGITS - 1);

endpackage
`default_nettype wire

// ===== sv/dsss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsss_front (
	input  wire logic [7:0]      char_code,
	input  wire logic            end_of_string,
	output dsss_pkg::token_t     tok
);
	import dsss_pkg::*;

	always_comb begin
		tok.digit = char_code[3:0];
		tok.last  = end_of_string;
		if (char_code == 8'd0) begin
			tok.cls = CLS_NUL;
		end else if (char_code inside {[8'd48:8'd57]}) begin
			tok.cls = CLS_DIGIT;
		end else if (char_code inside {8'd69, 8'd101}) begin
			tok.cls = CLS_EXP;
		end else if (char_code == 8'd43) begin
			tok.cls = CLS_PLUS;
		end else if (char_code == 8'd45) begin
			tok.cls = CLS_MINUS;
		end else if (char_code == 8'd46) begin
			tok.cls = CLS_POINT;
		end else if (char_code inside {8'd32, [8'd9:8'd13]}) begin
			tok.cls = CLS_SPACE;
		end else begin
			tok.cls = CLS_OTHER;
		end
	end

endmodule
`default_nettype wire

// ===== sv/dsss_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsss_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dsss_pkg::token_t push_tok,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output dsss_pkg::token_t      head_tok
);
	import dsss_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	token_t              entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_QW-1:0]   count_q;

	assign full      = (count_q == CNT_QW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_tok  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_QW'(1);
				2'b01:   count_q <= count_q - CNT_QW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/dsss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsss_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tok_valid,
	input  wire dsss_pkg::token_t      tok,
	output logic                       tok_pop,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic                       negative,
	output logic [63:0]                mantissa,
	output logic signed [15:0]         decimal_exponent,
	output logic                       digits_dropped,
	output logic                       exponent_saturated
);
	import dsss_pkg::*;

	localparam logic signed [16:0]  LIM_P = 17'(EXP_LIMIT);
	localparam logic signed [16:0]  LIM_N = -LIM_P;
	localparam logic [17:0]         LIM_E = 18'(EXP_LIMIT);
	localparam logic [EACC_W-1:0]   LIM_A = EACC_W'(EXP_LIMIT);
	localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_DIGITS);

	phase_t                phase_q, phase_n;
	logic                  neg_q, neg_n;
	logic [63:0]           mant_q, mant_n;
	logic [CNT_W-1:0]      cnt_q, cnt_n;
	logic signed [15:0]    scale_q, scale_n;
	logic [EACC_W-1:0]     eacc_q, eacc_n;
	logic                  eneg_q, eneg_n;
	logic                  drop_q, drop_n;
	logic                  clamp_q, clamp_n;

	logic                  early_e;
	logic                  active;
	logic                  dig_int, dig_frac, base_sign, exp_sign, exp_dig;
	logic                  lead_zero, room;
	logic [63:0]           mant10;
	logic signed [1:0]     delta;
	logic signed [16:0]    sc_try;
	logic [17:0]           ev;
	logic signed [16:0]    e_mag, e_part, e_sum;
	logic signed [16:0]    e_fin;
	logic                  fin_clamp;
	logic                  load;

	// an end item needs the output register free; others always drain
	assign tok_pop = tok_valid && (!tok.last || !result_valid || !result_stall);
	assign load    = tok_pop && tok.last;

	assign early_e = (phase_q inside {PH_SPACE, PH_INT, PH_FRAC, PH_SKIP}) && (tok.cls == CLS_EXP);

	// next scan phase
	always_comb begin
		phase_n = phase_q;
		if (tok_pop) begin
			if (phase_q == PH_DONE) begin
				phase_n = PH_DONE;
			end else if (tok.cls == CLS_NUL) begin
				phase_n = PH_DONE;
			end else if (early_e) begin
				phase_n = PH_EXP_START;
			end else begin
				case (phase_q)
					PH_SPACE: begin
						if (tok.cls inside {CLS_PLUS, CLS_MINUS, CLS_DIGIT}) begin
							phase_n = PH_INT;
						end else if (tok.cls == CLS_POINT) begin
							phase_n = PH_FRAC;
						end else if (tok.cls != CLS_SPACE) begin
							phase_n = PH_SKIP;
						end
					end
					PH_INT: begin
						if (tok.cls == CLS_POINT) begin
							phase_n = PH_FRAC;
						end else if (tok.cls != CLS_DIGIT) begin
							phase_n = PH_SKIP;
						end
					end
					PH_FRAC: begin
						if (tok.cls != CLS_DIGIT) begin
							phase_n = PH_SKIP;
						end
					end
					PH_SKIP: phase_n = PH_SKIP;
					PH_EXP_START, PH_EXP_DIGITS: begin
						if (tok.cls inside {CLS_DIGIT}) begin
							phase_n = PH_EXP_DIGITS;
						end else if (phase_q == PH_EXP_START &&
								(tok.cls == CLS_PLUS || tok.cls == CLS_MINUS)) begin
							phase_n = PH_EXP_DIGITS;
						end else begin
							phase_n = PH_DONE;
						end
					end
					default: phase_n = PH_DONE;
				endcase
			end
		end
	end

	// actions decoded from phase and class
	always_comb begin
		active    = tok_pop && (phase_q != PH_DONE) && (tok.cls != CLS_NUL) && !early_e;
		dig_int   = active && (tok.cls == CLS_DIGIT) && (phase_q inside {PH_SPACE, PH_INT});
		dig_frac  = active && (tok.cls == CLS_DIGIT) && (phase_q == PH_FRAC);
		base_sign = active && (phase_q == PH_SPACE) &&
			(tok.cls == CLS_PLUS || tok.cls == CLS_MINUS);
		exp_sign  = active && (phase_q == PH_EXP_START) &&
			(tok.cls == CLS_PLUS || tok.cls == CLS_MINUS);
		exp_dig   = active && (tok.cls == CLS_DIGIT) &&
			(phase_q inside {PH_EXP_START, PH_EXP_DIGITS});
	end

	// accumulator updates
	always_comb begin
		mant_n  = mant_q;
		cnt_n   = cnt_q;
		scale_n = scale_q;
		eacc_n  = eacc_q;
		neg_n   = neg_q;
		eneg_n  = eneg_q;
		drop_n  = drop_q;
		clamp_n = clamp_q;
		delta   = 2'sd0;

		lead_zero = (mant_q == 64'd0) && (tok.digit == 4'd0);
		room      = (cnt_q < CNT_MAX);
		mant10    = (mant_q << 3) + (mant_q << 1) + 64'(tok.digit);

		if (dig_int || dig_frac) begin
			if (lead_zero) begin
				delta = dig_frac ? -2'sd1 : 2'sd0;
			end else if (room) begin
				mant_n = mant10;
				cnt_n  = cnt_q + CNT_W'(1);
				delta  = dig_frac ? -2'sd1 : 2'sd0;
			end else begin
				if (tok.digit != 4'd0) begin
					drop_n = 1'b1;
				end
				delta = dig_frac ? 2'sd0 : 2'sd1;
			end
		end
		sc_try = 17'(scale_q) + 17'(delta);
		if (sc_try > LIM_P) begin
			scale_n = 16'(LIM_P);
			clamp_n = 1'b1;
		end else if (sc_try < LIM_N) begin
			scale_n = 16'(LIM_N);
			clamp_n = 1'b1;
		end else begin
			scale_n = 16'(sc_try);
		end

		if (base_sign) begin
			neg_n = (tok.cls == CLS_MINUS);
		end
		if (exp_sign) begin
			eneg_n = (tok.cls == CLS_MINUS);
		end

		ev = (18'(eacc_q) << 3) + (18'(eacc_q) << 1) + 18'(tok.digit);
		if (exp_dig) begin
			if (ev > LIM_E) begin
				eacc_n  = LIM_A;
				clamp_n = 1'b1;
			end else begin
				eacc_n = EACC_W'(ev);
			end
		end
	end

	// final exponent: scale plus signed exponent digits, clamped
	always_comb begin
		e_mag  = signed'(17'(eacc_n));
		e_part = eneg_n ? -e_mag : e_mag;
		e_sum  = 17'(scale_n) + e_part;
		fin_clamp = 1'b0;
		if (e_sum > LIM_P) begin
			e_fin     = LIM_P;
			fin_clamp = 1'b1;
		end else if (e_sum < LIM_N) begin
			e_fin     = LIM_N;
			fin_clamp = 1'b1;
		end else begin
			e_fin = e_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			mant_q  <= '0;
			cnt_q   <= '0;
			scale_q <= '0;
			eacc_q  <= '0;
			eneg_q  <= 1'b0;
			drop_q  <= 1'b0;
			clamp_q <= 1'b0;
		end else if (load) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			mant_q  <= '0;
			cnt_q   <= '0;
			scale_q <= '0;
			eacc_q  <= '0;
			eneg_q  <= 1'b0;
			drop_q  <= 1'b0;
			clamp_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			mant_q  <= mant_n;
			cnt_q   <= cnt_n;
			scale_q <= scale_n;
			eacc_q  <= eacc_n;
			eneg_q  <= eneg_n;
			drop_q  <= drop_n;
			clamp_q <= clamp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			negative           <= neg_n;
			mantissa           <= mant_n;
			decimal_exponent   <= 16'(e_fin);
			digits_dropped     <= drop_n;
			exponent_saturated <= clamp_n || fin_clamp;
		end
	end

endmodule
`default_nettype wire

// ===== sv/decimal_scientific_string_scanner.sv =====
// a result is loaded when its end item is taken and is valid from the next cycle
// throughput: one character per cycle; the scanner drains one queued character a cycle,
// but an end item waits in the queue only while the last result is stalled at the output
// the character queue holds QUEUE_DEPTH items and stalls the input when full
// reset (arst_n low, asynchronous): queue empty, scan state cleared, no result pending
`timescale 1ns / 1ps
`default_nettype none
module decimal_scientific_string_scanner #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           char_valid,
	output logic                char_stall,
	input  wire logic [7:0]     char_code,
	input  wire logic           end_of_string,
	output logic                result_valid,
	input  wire logic           result_stall,
	output logic                negative,
	output logic [63:0]         mantissa,
	output logic signed [15:0]  decimal_exponent,
	output logic                digits_dropped,
	output logic                exponent_saturated
);
	import dsss_pkg::*;

	token_t in_tok;
	token_t head_tok;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;
	logic   q_push;

	assign char_stall = q_full;
	assign q_push     = char_valid && !q_full;

	dsss_front u_front (
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.tok           (in_tok)
	);

	dsss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_tok  (in_tok),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_tok  (head_tok)
	);

	dsss_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.tok_valid          (q_not_empty),
		.tok                (head_tok),
		.tok_pop            (q_pop),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.negative           (negative),
		.mantissa           (mantissa),
		.decimal_exponent   (decimal_exponent),
		.digits_dropped     (digits_dropped),
		.exponent_saturated (exponent_saturated)
	);

endmodule
`default_nettype wire

// ===== sv/dsss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_scientific_string_scanner_macros.svh"
module dsss_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic               negative,
	input wire logic [63:0]        mantissa,
	input wire logic signed [15:0] decimal_exponent,
	input wire logic               digits_dropped,
	input wire logic               exponent_saturated
);
	import dsss_pkg::*;

	localparam logic signed [15:0] EXP_HI = 16'(EXP_LIMIT);
	localparam logic signed [15:0] EXP_LO = -EXP_HI;

	`DSSS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(mantissa) && $stable(decimal_exponent) && $stable(negative) && $stable(digits_dropped) && $stable(exponent_saturated), "result changed while stalled")
	`DSSS_ASSERT_IMPL(a_exp_range, clk, arst_n, result_valid, decimal_exponent <= EXP_HI && decimal_exponent >= EXP_LO, "exponent outside limit")
	`DSSS_ASSERT_IMPL(a_mant_range, clk, arst_n, result_valid, mantissa <= MANT_MAX, "mantissa has too many digits")
	`DSSS_ASSERT_IMPL(a_drop_full, clk, arst_n, result_valid && digits_dropped, mantissa >= MANT_FULL_MIN, "digits dropped with mantissa not full")

endmodule

bind decimal_scientific_string_scanner dsss_checker u_dsss_checker (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import dsss_pkg::*;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] CH_DIGIT9  = 8'h39;
	localparam logic [7:0] CH_E_UPPER = 8'h45;
	localparam logic [7:0] CH_E_LOWER = 8'h65;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_CHARS = 335;

	typedef struct {
		logic               neg;
		logic [63:0]        mant;
		logic signed [15:0] power;
		logic               dropped;
		logic               saturated;
	} number_t;

	logic clk = 1'b0;
	logic arst_n;
	logic char_valid;
	logic char_stall;
	logic [7:0] char_code;
	logic end_of_string;
	logic result_valid;
	logic result_stall;
	logic negative;
	logic [63:0] mantissa;
	logic signed [15:0] decimal_exponent;
	logic digits_dropped;
	logic exponent_saturated;

	// scanner state mirrored by the predictor
	phase_t sc_phase;
	logic sc_neg;
	logic [63:0] sc_mant;
	int sc_count;
	int sc_scale;
	int sc_exp;
	logic sc_exp_neg;
	logic sc_dropped;
	logic sc_clamped;

	number_t pending_numbers[$];
	logic [7:0] number_text[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	decimal_scientific_string_scanner u_top (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.end_of_string(end_of_string),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.negative(negative),
		.mantissa(mantissa),
		.decimal_exponent(decimal_exponent),
		.digits_dropped(digits_dropped),
		.exponent_saturated(exponent_saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_power(input int v);
		if (v > EXP_LIMIT) begin
			sc_clamped = 1'b1;
			return EXP_LIMIT;
		end
		if (v < -EXP_LIMIT) begin
			sc_clamped = 1'b1;
			return -EXP_LIMIT;
		end
		return v;
	endfunction

	task automatic clear_scanner();
		sc_phase = PH_SPACE;
		sc_neg = 1'b0;
		sc_mant = 64'd0;
		sc_count = 0;
		sc_scale = 0;
		sc_exp = 0;
		sc_exp_neg = 1'b0;
		sc_dropped = 1'b0;
		sc_clamped = 1'b0;
	endtask

	task automatic absorb_digit(input logic [3:0] d, input logic frac);
		// zeros ahead of the first significant digit are not stored; in the fraction they shift the point
		if (sc_mant == 64'd0 && d == 4'd0) begin
			if (frac)
				sc_scale = clamp_power(sc_scale - 1);
			return;
		end
		if (sc_count < MAX_DIGITS) begin
			sc_mant = sc_mant * 64'd10 + 64'(d);
			sc_count++;
			if (frac)
				sc_scale = clamp_power(sc_scale - 1);
		end else begin
			if (d != 4'd0)
				sc_dropped = 1'b1;
			if (!frac)
				sc_scale = clamp_power(sc_scale + 1);
		end
	endtask

	task automatic scan_char(input logic [7:0] c);
		logic is_digit;
		logic is_e;
		logic is_sign;
		logic is_space;
		logic [7:0] d;
		is_digit = c >= CH_DIGIT0 && c <= CH_DIGIT9;
		is_e = c == CH_E_UPPER || c == CH_E_LOWER;
		is_sign = c == CH_PLUS || c == CH_MINUS;
		is_space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		d = c - CH_DIGIT0;
		if (sc_phase == PH_DONE)
			return;
		if (c == CH_NUL) begin
			sc_phase = PH_DONE;
			return;
		end
		if (sc_phase <= PH_SKIP && is_e) begin
			sc_phase = PH_EXP_START;
			return;
		end
		case (sc_phase)
			PH_SPACE: begin
				if (!is_space) begin
					if (is_sign) begin
						sc_neg = c == CH_MINUS;
						sc_phase = PH_INT;
					end else if (is_digit) begin
						absorb_digit(d[3:0], 1'b0);
						sc_phase = PH_INT;
					end else if (c == CH_POINT) begin
						sc_phase = PH_FRAC;
					end else begin
						sc_phase = PH_SKIP;
					end
				end
			end
			PH_INT: begin
				if (is_digit)
					absorb_digit(d[3:0], 1'b0);
				else
					sc_phase = (c == CH_POINT) ? PH_FRAC : PH_SKIP;
			end
			PH_FRAC: begin
				if (is_digit)
					absorb_digit(d[3:0], 1'b1);
				else
					sc_phase = PH_SKIP;
			end
			PH_SKIP: begin
			end
			PH_EXP_START, PH_EXP_DIGITS: begin
				if (sc_phase == PH_EXP_START && is_sign) begin
					sc_exp_neg = c == CH_MINUS;
					sc_phase = PH_EXP_DIGITS;
				end else if (is_digit) begin
					sc_exp = clamp_power(sc_exp * 10 + int'(d));
					sc_phase = PH_EXP_DIGITS;
				end else begin
					sc_phase = PH_DONE;
				end
			end
			default: sc_phase = PH_DONE;
		endcase
	endtask

	task automatic predict_char(input logic [7:0] c, input logic last);
		number_t num;
		int e;
		scan_char(c);
		if (last) begin
			e = sc_exp_neg ? -sc_exp : sc_exp;
			e = clamp_power(sc_scale + e);
			num.neg = sc_neg;
			num.mant = sc_mant;
			num.power = e[15:0];
			num.dropped = sc_dropped;
			num.saturated = sc_clamped;
			pending_numbers.push_back(num);
			clear_scanner();
		end
	endtask

	// acceptance is decided at the falling edge, the item moves at the next rising edge
	task automatic send_char(input logic [7:0] code, input logic last);
		logic taken;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= code;
		end_of_string <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !char_stall;
			if (taken)
				predict_char(code, last);
			@(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last && i == s.len() - 1);
	endtask

	function automatic int digit_run();
		return ($urandom_range(9, 0) == 0) ? $urandom_range(24, 15) : $urandom_range(4, 0);
	endfunction

	task automatic push_digits(input int n, input int zero_pct);
		repeat (n) begin
			if ($urandom_range(99, 0) < zero_pct)
				number_text.push_back(CH_DIGIT0);
			else
				number_text.push_back(CH_DIGIT0 + 8'($urandom_range(9, 0)));
		end
	endtask

	task automatic build_number();
		number_text.delete();
		// plain noise
		if ($urandom_range(99, 0) < 12) begin
			repeat ($urandom_range(8, 1))
				number_text.push_back(8'($urandom_range(255, 0)));
			return;
		end
		repeat ($urandom_range(2, 0)) begin
			if ($urandom_range(1, 0) == 1)
				number_text.push_back(CH_SPACE);
			else
				number_text.push_back(CH_TAB + 8'($urandom_range(4, 0)));
		end
		case ($urandom_range(2, 0))
			1: number_text.push_back(CH_PLUS);
			2: number_text.push_back(CH_MINUS);
			default: begin
			end
		endcase
		push_digits(digit_run(), 30);
		if ($urandom_range(99, 0) < 60) begin
			number_text.push_back(CH_POINT);
			push_digits(digit_run(), 30);
		end
		if ($urandom_range(99, 0) < 60) begin
			number_text.push_back($urandom_range(1, 0) ? CH_E_UPPER : CH_E_LOWER);
			case ($urandom_range(2, 0))
				1: number_text.push_back(CH_PLUS);
				2: number_text.push_back(CH_MINUS);
				default: begin
				end
			endcase
			push_digits(($urandom_range(99, 0) < 15) ? $urandom_range(7, 5)
				: $urandom_range(3, 0), 10);
		end
		if ($urandom_range(99, 0) < 10)
			number_text.push_back(8'($urandom_range(255, 0)));
		if (number_text.size() == 0)
			number_text.push_back(8'($urandom_range(255, 0)));
		// broken strings: a stray byte or an embedded terminator
		if ($urandom_range(99, 0) < 10)
			number_text[$urandom_range(number_text.size() - 1, 0)] = 8'($urandom_range(255, 0));
		if ($urandom_range(99, 0) < 5)
			number_text.insert($urandom_range(number_text.size() - 1, 0), CH_NUL);
	endtask

	task automatic run_numbers(input int n_chars);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			build_number();
			for (int i = 0; i < number_text.size(); i++)
				send_char(number_text[i], i == number_text.size() - 1);
			sent += number_text.size();
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		send_text("\t-0.0", 1'b1);
		send_text("+1e", 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("5", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_text("7e3", 1'b1);
		send_text(".e-9", 1'b1);
		send_text("2E+99999", 1'b1);
	endtask

	task automatic test_no_idle();
		send_idle_pct = 0;
		stall_pct = 0;
		run_numbers(PHASE_CHARS);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 51;
		stall_pct = 0;
		run_numbers(PHASE_CHARS);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		stall_pct = 51;
		run_numbers(PHASE_CHARS);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 12;
		stall_pct = 12;
		run_numbers(PHASE_CHARS);
	endtask

	always @(posedge clk)
		result_stall <= $urandom_range(99, 0) < stall_pct;

	task automatic report_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected 'h%0h, got 'h%0h", field, want, got);
	endtask

	always @(negedge clk) begin
		number_t num;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_numbers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending: mantissa 'h%0h", mantissa);
			end else begin
				num = pending_numbers.pop_front();
				if (negative !== num.neg)
					report_mismatch("negative", 64'(num.neg), 64'(negative));
				if (mantissa !== num.mant)
					report_mismatch("mantissa", num.mant, mantissa);
				if (decimal_exponent !== num.power)
					report_mismatch("decimal_exponent", 64'(num.power), 64'(decimal_exponent));
				if (digits_dropped !== num.dropped)
					report_mismatch("digits_dropped", 64'(num.dropped), 64'(digits_dropped));
				if (exponent_saturated !== num.saturated)
					report_mismatch("exponent_saturated", 64'(num.saturated),
						64'(exponent_saturated));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_code = 8'd0;
		end_of_string = 1'b0;
		result_stall = 1'b0;
		clear_scanner();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		char_valid <= 1'b0;
		while (pending_numbers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_numbers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
